// ===== hw/rtl/rmth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_pkg: shared types for the running median block
// Heap operation codes, heap and sequencer states, request and status structs.
// ----------------------------------------------------------------------------
package rmth_pkg;

	localparam int SW = 16;

	typedef logic signed [SW-1:0] sample_t;

	typedef enum logic {
		OP_PUSH,
		OP_REPLACE
	} heap_op_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_UP_RD,
		H_UP_CMP,
		H_DN_RDL,
		H_DN_RDR,
		H_DN_CMP
	} heap_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_PUSH,
		T_CHECK,
		T_SWAP,
		T_OUT
	} top_state_t;

	typedef struct packed {
		logic     start;
		heap_op_t op;
		sample_t  value;
	} heap_req_t;

	typedef struct packed {
		logic    done;
		sample_t top;
	} heap_stat_t;

	// True if a belongs above b in the heap order.
	function automatic logic above(input sample_t a, input sample_t b, input logic is_max);
		above = is_max ? (a > b) : (a < b);
	endfunction

endpackage

// ===== hw/rtl/rmth_heap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_heap: one binary heap in a single-port-read memory
// Push with sift-up and replace-top with sift-down, one level per pass.
// ----------------------------------------------------------------------------
module rmth_heap #(
	parameter int DEPTH  = 512,
	parameter bit IS_MAX = 1'b1,
	parameter int CW     = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmth_pkg::heap_req_t req,
	output rmth_pkg::heap_stat_t stat,
	output logic [CW-1:0]       count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW = AW + 2;

	rmth_pkg::heap_state_t state_q, state_n;
	logic [AW-1:0]    idx_q, idx_n;
	logic [CW-1:0]    cnt_q, cnt_n;
	rmth_pkg::sample_t val_q, val_n;
	rmth_pkg::sample_t lv_q, lv_n;
	logic             rok_q, rok_n;
	rmth_pkg::sample_t top_q;
	rmth_pkg::sample_t rdata_q;
	rmth_pkg::sample_t mem [DEPTH];

	logic             rd_en, wr_en, done;
	logic [AW-1:0]    rd_addr, wr_addr;
	rmth_pkg::sample_t wr_data;

	logic [AW-1:0]    parent;
	logic [EW-1:0]    l_ext, r_ext, cnt_ext;
	logic             take_r;
	rmth_pkg::sample_t cv;
	logic [AW-1:0]    ci;

	assign parent  = AW'((idx_q - AW'(1)) >> 1);
	assign l_ext   = EW'({idx_q, 1'b1});
	assign r_ext   = l_ext + EW'(1);
	assign cnt_ext = EW'(cnt_q);
	assign take_r  = rok_q && rmth_pkg::above(rdata_q, lv_q, IS_MAX);
	assign cv      = take_r ? rdata_q : lv_q;
	assign ci      = take_r ? r_ext[AW-1:0] : l_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en && wr_addr == '0) begin
			top_q <= wr_data;
		end
		idx_q <= idx_n;
		val_q <= val_n;
		lv_q  <= lv_n;
		rok_q <= rok_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmth_pkg::H_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	always_comb begin
		state_n = state_q;
		idx_n   = idx_q;
		cnt_n   = cnt_q;
		val_n   = val_q;
		lv_n    = lv_q;
		rok_n   = rok_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = val_q;
		done    = 1'b0;
		case (state_q)
			rmth_pkg::H_IDLE: begin
				if (req.start) begin
					val_n = req.value;
					if (req.op == rmth_pkg::OP_PUSH) begin
						idx_n   = cnt_q[AW-1:0];
						cnt_n   = cnt_q + CW'(1);
						state_n = rmth_pkg::H_UP_RD;
					end else begin
						idx_n   = '0;
						state_n = rmth_pkg::H_DN_RDL;
					end
				end
			end
			rmth_pkg::H_UP_RD: begin
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					done    = 1'b1;
					state_n = rmth_pkg::H_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent;
					state_n = rmth_pkg::H_UP_CMP;
				end
			end
			rmth_pkg::H_UP_CMP: begin
				wr_en = 1'b1;
				if (rmth_pkg::above(val_q, rdata_q, IS_MAX)) begin
					wr_data = rdata_q;
					idx_n   = parent;
					state_n = rmth_pkg::H_UP_RD;
				end else begin
					done    = 1'b1;
					state_n = rmth_pkg::H_IDLE;
				end
			end
			rmth_pkg::H_DN_RDL: begin
				if (l_ext >= cnt_ext) begin
					wr_en   = 1'b1;
					done    = 1'b1;
					state_n = rmth_pkg::H_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = l_ext[AW-1:0];
					state_n = rmth_pkg::H_DN_RDR;
				end
			end
			rmth_pkg::H_DN_RDR: begin
				lv_n    = rdata_q;
				rok_n   = r_ext < cnt_ext;
				rd_en   = r_ext < cnt_ext;
				rd_addr = r_ext[AW-1:0];
				state_n = rmth_pkg::H_DN_CMP;
			end
			rmth_pkg::H_DN_CMP: begin
				wr_en = 1'b1;
				if (rmth_pkg::above(cv, val_q, IS_MAX)) begin
					wr_data = cv;
					idx_n   = ci;
					state_n = rmth_pkg::H_DN_RDL;
				end else begin
					done    = 1'b1;
					state_n = rmth_pkg::H_IDLE;
				end
			end
			default: begin
				state_n = rmth_pkg::H_IDLE;
			end
		endcase
	end

	assign stat.done = done;
	assign stat.top  = top_q;
	assign count     = cnt_q;

	// The fill count never passes the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("heap count above capacity");

	// A new operation is only requested while the engine is idle.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == rmth_pkg::H_IDLE)
		else $error("heap started while busy");

	// The count moves only on a push start, and then by one.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.start && req.op == rmth_pkg::OP_PUSH && state_q == rmth_pkg::H_IDLE)
		|=> $stable(cnt_q))
		else $error("heap count changed without a push");

endmodule

// ===== hw/rtl/running_median_two_heaps.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps: running lower median over a stream of samples
// Two heaps in block memory, each walked one level at a time by its engine.
// ----------------------------------------------------------------------------
// Each input beat carries one signed 16-bit sample and yields one output beat
// with the lower median of all samples taken so far. Samples alternate between
// a max-heap holding the lower half and a min-heap holding the upper half;
// when the lower top exceeds the upper top the two tops are exchanged and both
// heaps sift down in parallel. A result is formed in steps: the sift-up of the
// push, a compare of the two tops, the exchange if one is needed, and a
// register for the result. A dropped beat skips the heaps and goes straight
// to the result register. The heap walk goes one level per pass through a
// single registered memory read port. The block takes no new beat until the
// previous result has been delivered, and accepts again the cycle after that.
// After 2*HEAP_DEPTH samples, further beats are flagged as dropped and repeat
// the current median.
module running_median_two_heaps #(
	parameter int HEAP_DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [15:0]       sample_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [15:0]       median_value,
	output logic                     dropped
);

	localparam int CW = $clog2(HEAP_DEPTH + 1);

	rmth_pkg::top_state_t state_q, state_n;
	rmth_pkg::heap_req_t  lo_req, up_req;
	rmth_pkg::heap_stat_t lo_stat, up_stat;
	logic [CW-1:0]        lo_cnt, up_cnt;
	logic [CW:0]          total;
	logic                 full, accept;
	logic                 lo_dn_q, up_dn_q, lo_dn_n, up_dn_n;
	logic                 drop_q, drop_n;
	logic                 out_valid_q;
	rmth_pkg::sample_t    median_q;
	logic                 dropped_q;

	assign total    = {1'b0, lo_cnt} + {1'b0, up_cnt};
	assign full     = total >= (CW + 1)'(2 * HEAP_DEPTH);
	assign in_stall = !(state_q == rmth_pkg::T_IDLE && !out_valid_q);
	assign accept   = in_valid && !in_stall;

	rmth_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b1), .CW(CW)) u_lower (
		.clk(clk), .arst_n(arst_n), .req(lo_req), .stat(lo_stat), .count(lo_cnt)
	);

	rmth_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b0), .CW(CW)) u_upper (
		.clk(clk), .arst_n(arst_n), .req(up_req), .stat(up_stat), .count(up_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmth_pkg::T_IDLE;
			out_valid_q <= 1'b0;
			lo_dn_q     <= 1'b0;
			up_dn_q     <= 1'b0;
			drop_q      <= 1'b0;
		end else begin
			state_q <= state_n;
			lo_dn_q <= lo_dn_n;
			up_dn_q <= up_dn_n;
			drop_q  <= drop_n;
			if (state_q == rmth_pkg::T_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result beat is captured once both heaps have settled.
	always_ff @(posedge clk) begin
		if (state_q == rmth_pkg::T_OUT) begin
			median_q  <= lo_stat.top;
			dropped_q <= drop_q;
		end
	end

	always_comb begin
		state_n      = state_q;
		lo_dn_n      = lo_dn_q;
		up_dn_n      = up_dn_q;
		drop_n       = drop_q;
		lo_req.start = 1'b0;
		lo_req.op    = rmth_pkg::OP_PUSH;
		lo_req.value = sample_value;
		up_req.start = 1'b0;
		up_req.op    = rmth_pkg::OP_PUSH;
		up_req.value = sample_value;
		case (state_q)
			rmth_pkg::T_IDLE: begin
				if (accept) begin
					drop_n = full;
					if (full) begin
						state_n = rmth_pkg::T_OUT;
					end else begin
						// Even arrivals feed the lower heap, odd ones the upper.
						lo_req.start = !total[0];
						up_req.start = total[0];
						state_n      = rmth_pkg::T_PUSH;
					end
				end
			end
			rmth_pkg::T_PUSH: begin
				if (lo_stat.done || up_stat.done) begin
					state_n = rmth_pkg::T_CHECK;
				end
			end
			rmth_pkg::T_CHECK: begin
				if (lo_cnt != '0 && up_cnt != '0 && lo_stat.top > up_stat.top) begin
					lo_req.start = 1'b1;
					lo_req.op    = rmth_pkg::OP_REPLACE;
					lo_req.value = up_stat.top;
					up_req.start = 1'b1;
					up_req.op    = rmth_pkg::OP_REPLACE;
					up_req.value = lo_stat.top;
					lo_dn_n      = 1'b0;
					up_dn_n      = 1'b0;
					state_n      = rmth_pkg::T_SWAP;
				end else begin
					state_n = rmth_pkg::T_OUT;
				end
			end
			rmth_pkg::T_SWAP: begin
				lo_dn_n = lo_dn_q || lo_stat.done;
				up_dn_n = up_dn_q || up_stat.done;
				if ((lo_dn_q || lo_stat.done) && (up_dn_q || up_stat.done)) begin
					state_n = rmth_pkg::T_OUT;
				end
			end
			rmth_pkg::T_OUT: begin
				state_n = rmth_pkg::T_IDLE;
			end
			default: begin
				state_n = rmth_pkg::T_IDLE;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign median_value = median_q;
	assign dropped      = dropped_q;

	// The sequencer leaves idle only on an accepted beat.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmth_pkg::T_IDLE && state_n != rmth_pkg::T_IDLE) |-> accept)
		else $error("sequencer left idle without a beat");

	// A push goes to exactly one heap.
	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmth_pkg::T_IDLE) |-> !(lo_req.start && up_req.start))
		else $error("push issued to both heaps");

	// The two heap counts never differ by more than one, lower never behind.
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmth_pkg::T_IDLE) |-> (lo_cnt == up_cnt || lo_cnt == up_cnt + CW'(1)))
		else $error("heap counts out of balance");

endmodule

// ===== tb/sv/running_median_two_heaps_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_test: self-checking bench for the running median
// Drives signed samples through the valid/stall handshake, predicts the lower
// median with a two-heap model of its own and compares every output beat.
// ----------------------------------------------------------------------------

// Keeps the predicted heaps and the queue of medians still owed by the block.
class median_board;
	localparam int DEPTH = 512;

	logic signed [15:0] lo_heap[DEPTH];
	logic signed [15:0] hi_heap[DEPTH];
	int unsigned        lo_cnt;
	int unsigned        hi_cnt;
	logic signed [15:0] owed_median[$];
	logic               owed_drop[$];
	int unsigned        mismatches;
	int unsigned        beats_checked;
	int unsigned        drops_seen;

	function new();
		lo_cnt = 0;
		hi_cnt = 0;
		mismatches = 0;
		beats_checked = 0;
		drops_seen = 0;
	endfunction

	// Order test: max-heap when is_max is set, min-heap otherwise.
	function automatic bit sits_above(logic signed [15:0] a, logic signed [15:0] b, bit is_max);
		return is_max ? (a > b) : (a < b);
	endfunction

	function automatic void push_lo(logic signed [15:0] v);
		int unsigned i;
		int unsigned p;
		logic signed [15:0] t;
		i = lo_cnt;
		lo_heap[i] = v;
		lo_cnt++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!sits_above(lo_heap[i], lo_heap[p], 1))
				break;
			t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
			i = p;
		end
	endfunction

	function automatic void push_hi(logic signed [15:0] v);
		int unsigned i;
		int unsigned p;
		logic signed [15:0] t;
		i = hi_cnt;
		hi_heap[i] = v;
		hi_cnt++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!sits_above(hi_heap[i], hi_heap[p], 0))
				break;
			t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
			i = p;
		end
	endfunction

	// Replaces the top of one heap and sifts it down.
	function automatic void sift_top(bit is_max, logic signed [15:0] v);
		int unsigned i;
		int unsigned l;
		int unsigned c;
		int unsigned n;
		logic signed [15:0] t;
		i = 0;
		n = is_max ? lo_cnt : hi_cnt;
		if (is_max) lo_heap[0] = v; else hi_heap[0] = v;
		forever begin
			l = 2 * i + 1;
			if (l >= n)
				break;
			c = l;
			if (is_max) begin
				if (l + 1 < n && sits_above(lo_heap[l+1], lo_heap[l], 1)) c = l + 1;
				if (!sits_above(lo_heap[c], lo_heap[i], 1)) break;
				t = lo_heap[i]; lo_heap[i] = lo_heap[c]; lo_heap[c] = t;
			end else begin
				if (l + 1 < n && sits_above(hi_heap[l+1], hi_heap[l], 0)) c = l + 1;
				if (!sits_above(hi_heap[c], hi_heap[i], 0)) break;
				t = hi_heap[i]; hi_heap[i] = hi_heap[c]; hi_heap[c] = t;
			end
			i = c;
		end
	endfunction

	function automatic bit full();
		return lo_cnt + hi_cnt >= 2 * DEPTH;
	endfunction

	// Called for every accepted input beat.
	function automatic void note_sample(logic signed [15:0] v);
		logic signed [15:0] a;
		logic signed [15:0] b;
		bit drop;
		drop = full();
		if (!drop) begin
			if (((lo_cnt + hi_cnt) & 1) == 0) push_lo(v); else push_hi(v);
			if (lo_cnt >= 1 && hi_cnt >= 1 && lo_heap[0] > hi_heap[0]) begin
				a = lo_heap[0];
				b = hi_heap[0];
				sift_top(1, b);
				sift_top(0, a);
			end
		end
		owed_median.push_back(lo_heap[0]);
		owed_drop.push_back(drop);
	endfunction

	// Called for every accepted output beat.
	function automatic void check_beat(logic signed [15:0] med, logic drp);
		logic signed [15:0] em;
		logic ed;
		beats_checked++;
		if (owed_median.size() == 0) begin
			$error("output beat with no sample pending: median_value=%0d dropped=%0b",
				med, drp);
			mismatches++;
			return;
		end
		em = owed_median.pop_front();
		ed = owed_drop.pop_front();
		if (drp) drops_seen++;
		if (med !== em) begin
			$error("median_value: expected %0d, got %0d", em, med);
			mismatches++;
		end
		if (drp !== ed) begin
			$error("dropped: expected %0b, got %0b", ed, drp);
			mismatches++;
		end
	endfunction
endclass

module running_median_two_heaps_test;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] sample_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] median_value;
	logic               dropped;

	// Percent of cycles in which the sender idles and the receiver stalls.
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned samples_sent;

	median_board board;

	running_median_two_heaps dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_value(sample_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.median_value(median_value),
		.dropped(dropped)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// The receiver side: the stall is redrawn every cycle, and an output beat
	// is checked at the edge where valid is high and our stall is low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				board.check_beat(median_value, dropped);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Sends one sample: optional idle cycles first, then valid is held until
	// the block takes the beat. Valid stays high across back-to-back beats.
	task automatic send_sample(input logic signed [15:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_sample(v);
		samples_sent++;
	endtask

	// Drops valid and waits until every predicted median has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.owed_median.size() != 0)
			@(posedge clk);
	endtask

	// Mostly uniform samples, with a share of extremes and small values so
	// that equal tops and near-ties are common.
	function automatic logic signed [15:0] random_sample();
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0) return 16'sh7FFF;
		if (k == 1) return 16'sh8000;
		if (k < 4) return $signed(16'($urandom_range(8))) - 16'sd4;
		return 16'($urandom);
	endfunction

	initial begin
		#2000000;
		$display("running_median_two_heaps_test: done, errors");
		$finish;
	end

	initial begin
		board = new();
		samples_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: extremes, ties, ascending and descending runs so
		// that the tops get exchanged and also left in place.
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh0000);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		for (int i = 0; i < 6; i++)
			send_sample(16'(i * 1000));
		for (int i = 0; i < 6; i++)
			send_sample(16'(-i * 1000));
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		send_sample(16'sh0001);
		drain();

		// Random phases with different idle and stall mixes. The heaps fill
		// after 1024 samples, so the tail of the run exercises dropping, and
		// the drain between phases is the hold-off with nothing in flight.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 86; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 86; end
				3: begin idle_pct = 15; stall_pct = 15; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			for (int n = 0; n < 275; n++)
				send_sample(random_sample());
			drain();
		end

		idle_pct = 0;
		stall_pct = 0;
		repeat (100) @(posedge clk);
		$display("Sent %0d samples, checked %0d output beats, %0d of them dropped.",
			samples_sent, board.beats_checked, board.drops_seen);
		if (board.mismatches == 0 && board.owed_median.size() == 0)
			$display("running_median_two_heaps_test: done, clean");
		else
			$display("running_median_two_heaps_test: done, errors");
		$finish;
	end
endmodule
